[hw/rtl/swm_pkg.sv]
// Shared types, constants and helpers for the sliding-window median filter.
// No dependencies; imported by swm_cell and sliding_window_median.
`default_nettype none

package swm_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MEDIAN_W   = SAMPLE_W + 1;
   localparam int CSR_W      = 7;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPD,
      ST_MED
   } swm_state_type;

   // Broadcast to every cell of the sorted row
   typedef struct packed {
      logic                       en;
      logic                       drop;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] old;
   } swm_cell_ctl_type;

   // Saturate the programmed length into 1..MAX_WINDOW
   function automatic logic [LEN_W-1:0] eff_len(input logic [CSR_W-1:0] raw);
      logic [LEN_W-1:0] res;
      if (raw == '0) begin
         res = LEN_W'(1);
      end else if (32'(raw) > 32'(MAX_WINDOW)) begin
         res = LEN_W'(MAX_WINDOW);
      end else begin
         res = LEN_W'(raw);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/swm_cell.sv]
// One cell of the sorted row: holds one window entry and updates it from its
// neighbors on a remove-then-insert step. Depends on swm_pkg.
`default_nettype none

module swm_cell
   import swm_pkg::*;
(
   input  wire                         clock,
   input  swm_cell_ctl_type            ctl,
   input  wire                         keep_valid,  // entry index below kept count
   input  wire  signed [SAMPLE_W-1:0]  right_value, // stored entry of next cell
   input  wire  signed [SAMPLE_W-1:0]  left_kept,   // kept entry of previous cell
   input  wire                         left_le,     // previous kept entry <= sample
   output logic signed [SAMPLE_W-1:0]  value,
   output logic signed [SAMPLE_W-1:0]  kept,
   output logic                        kept_le
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   // Entries at or after the first copy of the dropped value shift down by one
   always_comb begin
      if (ctl.drop && !(value_ff < ctl.old)) begin
         kept = right_value;
      end else begin
         kept = value_ff;
      end
      kept_le = keep_valid && (kept <= ctl.sample);
   end

   always_comb begin
      priority if (kept_le) begin
         value_in = kept;
      end else if (left_le) begin
         value_in = ctl.sample;
      end else begin
         value_in = left_kept;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[hw/rtl/sliding_window_median.sv]
// Sliding-window median filter, top level: arrival ring, sorted cell row,
// control sequencer and result register. Depends on swm_pkg and swm_cell.
//
// Usage:
//   req_* carries one signed 32-bit sample per request. rsp_* carries twice
//   the median of the last window_len samples as a 33-bit two's complement
//   value (sum of the two middle entries for an even window).
//   csr_wen/csr_wdata set window_len (0 counts as 1, above 64 as 64) and empty
//   the window; write only while the block is idle.
//   No result comes out until the window has filled; after that every
//   request gives one result.
// Timing:
//   A request is taken in the idle state, where the oldest sample is read
//   from the ring. The next cycle updates every cell of the sorted row at
//   once, and the median state then selects the middle entries, adds them
//   and loads the result register, from which rsp_tvalid is driven. A new
//   request is accepted only back in the idle state, as the ring read, the
//   row update and the middle-entry add run in turn.
// Reset: window_len returns to 3 and the window is empty.
// Stall: a result waits in the output register; while it is not taken the
//   next request completes up to its add stage and then holds, and no
//   further request is accepted.
`default_nettype none

module sliding_window_median
   import swm_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [31:0]         req_tdata,  // [31:0] sample
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [39:0]         rsp_tdata,  // [32:0] median_twice, [39:33] zero
   input  wire                 csr_wen,
   input  wire  [CSR_W-1:0]    csr_wdata   // window_len
);

   swm_state_type state_ff, state_in;

   logic [LEN_W-1:0]           len_ff;
   logic [LEN_W-1:0]           fill_ff;
   logic [SLOT_W-1:0]          oldest_ff;
   logic                       full_ff;
   logic                       emit_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic                       rsp_valid_ff;
   logic [MEDIAN_W-1:0]        rsp_data_ff;

   logic [SAMPLE_W-1:0]        ring_mem [MAX_WINDOW];

   logic                       req_take;
   logic                       out_load;
   logic                       full_now;
   logic [LEN_W-1:0]           keep_cnt;
   logic [SLOT_W-1:0]          wr_slot;
   logic [SLOT_W-1:0]          oldest_next;
   swm_cell_ctl_type           cell_ctl;

   logic signed [SAMPLE_W-1:0] cell_value [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] cell_kept  [MAX_WINDOW];
   logic                       cell_le    [MAX_WINDOW];
   logic                       keep_valid [MAX_WINDOW];

   logic [SLOT_W-1:0]          mid_hi;
   logic [SLOT_W-1:0]          mid_lo;
   logic signed [SAMPLE_W-1:0] mid_a;
   logic signed [SAMPLE_W-1:0] mid_b;
   logic [MEDIAN_W-1:0]        median_sum;

   assign req_take = req_tvalid && req_tready;
   assign full_now = (fill_ff == len_ff);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            state_in = ST_MED;
         end
         ST_MED: begin
            if (!emit_ff || out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      out_load   = (state_ff == ST_MED) && emit_ff && (!rsp_valid_ff || rsp_tready);
      cell_ctl.en     = (state_ff == ST_UPD);
      cell_ctl.drop   = full_ff;
      cell_ctl.sample = sample_ff;
      cell_ctl.old    = old_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window bookkeeping
   assign keep_cnt    = full_ff ? (len_ff - LEN_W'(1)) : fill_ff;
   assign wr_slot     = full_ff ? oldest_ff : fill_ff[SLOT_W-1:0];
   assign oldest_next = (LEN_W'(oldest_ff) + LEN_W'(1) == len_ff) ?
                        '0 : (oldest_ff + SLOT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LEN_RESET;
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (csr_wen) begin
         len_ff    <= eff_len(csr_wdata);
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (state_ff == ST_UPD) begin
         if (full_ff) begin
            oldest_ff <= oldest_next;
         end else begin
            fill_ff <= fill_ff + LEN_W'(1);
         end
      end
   end

   // Capture the request and read the slot it will retire
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= $signed(req_tdata);
         full_ff   <= full_now;
         emit_ff   <= full_now || (fill_ff + LEN_W'(1) == len_ff);
         old_ff    <= $signed(ring_mem[oldest_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         ring_mem[wr_slot] <= sample_ff;
      end
   end

   // Sorted row
   genvar k;
   generate
      for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
         assign keep_valid[k] = (LEN_W'(k) < keep_cnt);
         if (k == 0) begin : g_first
            swm_cell u_cell (
               .clock       (clock),
               .ctl         (cell_ctl),
               .keep_valid  (keep_valid[k]),
               .right_value (cell_value[k+1]),
               .left_kept   ('0),
               .left_le     (1'b1),
               .value       (cell_value[k]),
               .kept        (cell_kept[k]),
               .kept_le     (cell_le[k])
            );
         end else if (k == MAX_WINDOW - 1) begin : g_last
            swm_cell u_cell (
               .clock       (clock),
               .ctl         (cell_ctl),
               .keep_valid  (keep_valid[k]),
               .right_value ('0),
               .left_kept   (cell_kept[k-1]),
               .left_le     (cell_le[k-1]),
               .value       (cell_value[k]),
               .kept        (cell_kept[k]),
               .kept_le     (cell_le[k])
            );
         end else begin : g_mid
            swm_cell u_cell (
               .clock       (clock),
               .ctl         (cell_ctl),
               .keep_valid  (keep_valid[k]),
               .right_value (cell_value[k+1]),
               .left_kept   (cell_kept[k-1]),
               .left_le     (cell_le[k-1]),
               .value       (cell_value[k]),
               .kept        (cell_kept[k]),
               .kept_le     (cell_le[k])
            );
         end
      end
   endgenerate

   // Middle entries: odd window doubles the center, even adds the two centers
   assign mid_hi     = SLOT_W'(len_ff >> 1);
   assign mid_lo     = mid_hi - SLOT_W'(1);
   assign mid_b      = cell_value[mid_hi];
   assign mid_a      = len_ff[0] ? cell_value[mid_hi] : cell_value[mid_lo];
   assign median_sum = MEDIAN_W'($signed({mid_a[SAMPLE_W-1], mid_a}) +
                                 $signed({mid_b[SAMPLE_W-1], mid_b}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= median_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(40 - MEDIAN_W)'(0), rsp_data_ff};

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill count beyond window length");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(oldest_ff) < len_ff)
      else $error("oldest slot outside window");

   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_UPD) ##1 (state_ff == ST_MED))
      else $error("request did not advance through update and median");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_MED) && $past(emit_ff))
      else $error("result appeared without a median step");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_median: random and directed sample requests,
// predicted against a sorted-window median in the bench. Depends on swm_pkg and the RTL.

module tb;
   import swm_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 8;
   localparam int RANDOM_ITEMS = 850;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                csr_wen    = 1'b0;
   logic [CSR_W-1:0]    csr_wdata  = '0;

   // Window state mirrored by the bench
   logic [CSR_W-1:0]          win_raw;
   logic signed [31:0]        arrival_samples[MAX_WINDOW];
   logic signed [31:0]        sorted_samples[MAX_WINDOW];
   int unsigned               fill_level;
   int unsigned               oldest_pos;

   logic [31:0]               samples_to_send[$];
   logic [MEDIAN_W-1:0]       pending_medians[$];
   int                        samples_unaccepted = 0;
   int                        mismatch_count     = 0;
   int                        send_gap           = 0;
   int                        recv_stall         = 0;
   int                        quiet_cycles       = 0;
   bit                        idle_on            = 1'b1;
   logic                      rsp_hold           = 1'b0;

   sliding_window_median i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned window_size();
      if (win_raw == '0) return 1;
      if (win_raw > MAX_WINDOW) return MAX_WINDOW;
      return win_raw;
   endfunction

   function automatic void insert_sorted(int unsigned n, logic signed [31:0] v);
      int unsigned i;
      i = n;
      while (i > 0 && sorted_samples[i-1] > v) begin
         sorted_samples[i] = sorted_samples[i-1];
         i--;
      end
      sorted_samples[i] = v;
   endfunction

   // Drop exactly one entry equal to v
   function automatic void remove_sorted(int unsigned n, logic signed [31:0] v);
      for (int i = 0; i < n; i++) begin
         if (sorted_samples[i] == v) begin
            for (int j = i; j + 1 < n; j++) sorted_samples[j] = sorted_samples[j+1];
            return;
         end
      end
   endfunction

   function automatic void advance_window(logic signed [31:0] v);
      int unsigned         l;
      int unsigned         slot;
      logic signed [31:0]  old;
      logic signed [31:0]  lo;
      logic signed [31:0]  hi;
      logic [MEDIAN_W-1:0] twice;
      l = window_size();
      if (fill_level < l) begin
         arrival_samples[fill_level] = v;
         insert_sorted(fill_level, v);
         fill_level++;
         if (fill_level < l) return;
         oldest_pos = 0;
      end else begin
         slot = oldest_pos % l;
         old = arrival_samples[slot];
         arrival_samples[slot] = v;
         oldest_pos = (slot + 1) % l;
         remove_sorted(l, old);
         insert_sorted(l - 1, v);
      end
      // For odd lengths both picks land on the middle entry
      lo = sorted_samples[(l - 1) / 2];
      hi = sorted_samples[l / 2];
      twice = {lo[31], lo} + {hi[31], hi};
      pending_medians = {pending_medians, twice};
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Request driver and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         win_raw = CSR_W'(LEN_RESET);
         fill_level = 0;
         oldest_pos = 0;
      end else begin
         if (csr_wen) begin
            win_raw = csr_wdata;
            fill_level = 0;
            oldest_pos = 0;
         end
         if (req_tvalid && req_tready) begin
            advance_window($signed(req_tdata));
            samples_unaccepted--;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= samples_to_send.pop_front();
               if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      logic [MEDIAN_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_medians.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d",
                                         $signed(rsp_tdata[MEDIAN_W-1:0])));
            end else begin
               want = pending_medians.pop_front();
               if (rsp_tdata[MEDIAN_W-1:0] !== want)
                  report_mismatch($sformatf("median_twice got %0d want %0d",
                                            $signed(rsp_tdata[MEDIAN_W-1:0]),
                                            $signed(want)));
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 17);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL sliding_window_median");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 6)) - 32'd3;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - 32'($urandom_range(0, 2))
                                        : 32'h80000000 + 32'($urandom_range(0, 2));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_sample(input logic [31:0] v);
      samples_to_send = {samples_to_send, v};
      samples_unaccepted++;
   endtask

   task automatic drain();
      do @(negedge clock); while (samples_unaccepted != 0 || pending_medians.size() != 0);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_window_len(input logic [CSR_W-1:0] v);
      drain();
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0]       odd_run[13] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                         32'h80000000, 32'h80000000, 32'h80000000,
                                         32'h00000000, 32'hFFFFFFFF, 32'h00000001,
                                         32'd5, 32'd5, 32'd5, 32'd2};
      logic [31:0]       even_run[8] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                         32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFE,
                                         32'd3, 32'd3};
      logic [CSR_W-1:0]  sweep[10]   = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65,
                                         7'd4, 7'd5, 7'd63, 7'd16, 7'd2};
      logic [CSR_W-1:0]  raw;
      int                eff;
      int                count;
      int                sent_random;
      sent_random = 0;
      wait (!reset);
      @(negedge clock);

      // Reset length of three: extremes and duplicates
      foreach (odd_run[i]) queue_sample(odd_run[i]);
      // Even window: sums of the two middle entries at both ends of the range
      write_window_len(7'd2);
      foreach (even_run[i]) queue_sample(even_run[i]);

      for (int p = 0; sent_random < RANDOM_ITEMS; p++) begin
         if (p < 10) raw = sweep[p];
         else if ($urandom_range(0, 4) == 0) raw = CSR_W'($urandom_range(13, 64));
         else raw = CSR_W'($urandom_range(1, 12));
         write_window_len(raw);
         eff = (raw == '0) ? 1 : ((raw > MAX_WINDOW) ? MAX_WINDOW : raw);
         // Now and then stop short of a full window before the next write
         if (p > 1 && p != 5 && $urandom_range(0, 4) == 0) count = $urandom_range(0, eff - 1);
         else count = eff + $urandom_range(15, 60);
         if (sent_random > 700) idle_on = 1'b0;
         repeat (count) queue_sample(random_sample());
         sent_random += count;
         if (p == 5) begin
            // Hold the result side so the block backs up into the request side
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("PASS sliding_window_median");
      end else begin
         $display("FAIL sliding_window_median");
      end
      $finish;
   end

endmodule

[sliding_window_median.f]
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_median.sv
tb/tb.sv
